// ----- rtl/core/dtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants for the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int SLOTS      = 16;
    localparam int ID_W       = 4;
    localparam int TIME_W     = 48;
    localparam int PER_W      = 32;
    localparam int CNT_W      = 5;
    localparam logic [PER_W-1:0] ROLL_RESET = 32'd3600000;

    typedef enum logic [2:0] {
        FN_ADD     = 3'd0,
        FN_CANCEL  = 3'd1,
        FN_REFRESH = 3'd2,
        FN_RESET   = 3'd3,
        FN_QUERY   = 3'd4,
        FN_COLLECT = 3'd5
    } dtt_func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETDL,
        ST_SCAN,
        ST_FIRE,
        ST_RESP
    } dtt_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic set_dl;
        logic scan_step;
        logic fire;
        logic resp;
    } dtt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       full;
        logic       reset_write;
        logic       idx_last;
        logic       found_n;
        logic       fire_last;
        logic       out_free;
    } dtt_stat_t;

    // saturating time plus period
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [PER_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W-PER_W+1){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// ----- rtl/core/dtt_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_ifs
// Valid/ready channels for operations, results and configuration.
// ----------------------------------------------------------------------------
interface dtt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [3:0]  timer_id;
    logic [31:0] period_ms;
    logic        recurring;
    logic        restart_now;
    logic [47:0] now_ms;
    modport source (output valid, func, timer_id, period_ms, recurring, restart_now, now_ms,
                    input ready);
    modport sink (input valid, func, timer_id, period_ms, recurring, restart_now, now_ms,
                  output ready);
endinterface

interface dtt_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [3:0]  slot_id;
    logic        fired;
    logic [47:0] wait_ms;
    logic        wake;
    logic        any_active;
    logic        last;
    modport source (output valid, ok, slot_id, fired, wait_ms, wake, any_active, last,
                    input ready);
    modport sink (input valid, ok, slot_id, fired, wait_ms, wake, any_active, last,
                  output ready);
endinterface

interface dtt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/deadline_timer_table.sv -----
`timescale 1ns / 1ps
// Sequencing: cancel, refresh, unknown codes, a full-table add and a reset that leaves the slot
// alone go from execute straight to the result; add and query scan all 16 slots; a rewriting
// reset sets the deadline, then scans; collect emits each fired timer after a 16-slot rescan.
// Throughput: one operation at a time; the next is accepted the cycle after the last result
// is registered, and every result waits for ready. Reset clears the active flags, the wake
// latch and the last collect time and sets the rollover window to 3600000 ms.
// ----------------------------------------------------------------------------
// deadline_timer_table
// Top level: joins the sequencer and the slot datapath.
// ----------------------------------------------------------------------------
module deadline_timer_table
(
    input  logic      clk,
    input  logic      rst_n,
    dtt_in_if.sink    in_ch,
    dtt_out_if.source out_ch,
    dtt_cfg_if.sink   cfg_ch
);

    dtt_pkg::dtt_cmd_t  cmd;
    dtt_pkg::dtt_stat_t stat;

    dtt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dtt_dp u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

// ----- rtl/core/dtt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer: steps each operation through execute and then, as its function needs, deadline set, scan, fire or respond.
// ----------------------------------------------------------------------------
module dtt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dtt_pkg::dtt_stat_t stat,
    output dtt_pkg::dtt_cmd_t  cmd
);

    dtt_pkg::dtt_state_t state_reg;
    dtt_pkg::dtt_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dtt_pkg::ST_EXEC;
                end
            end
            dtt_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority case (stat.func)
                    dtt_pkg::FN_ADD:
                        state_next = stat.full ? dtt_pkg::ST_RESP : dtt_pkg::ST_SCAN;
                    dtt_pkg::FN_RESET:
                        state_next = stat.reset_write ? dtt_pkg::ST_SETDL : dtt_pkg::ST_RESP;
                    dtt_pkg::FN_QUERY, dtt_pkg::FN_COLLECT:
                        state_next = dtt_pkg::ST_SCAN;
                    default:
                        state_next = dtt_pkg::ST_RESP;
                endcase
            end
            dtt_pkg::ST_SETDL:
            begin
                cmd.set_dl = 1'b1;
                state_next = dtt_pkg::ST_SCAN;
            end
            dtt_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.idx_last)
                begin
                    if (stat.func == dtt_pkg::FN_COLLECT && stat.found_n)
                    begin
                        state_next = dtt_pkg::ST_FIRE;
                    end
                    else
                    begin
                        state_next = dtt_pkg::ST_RESP;
                    end
                end
            end
            dtt_pkg::ST_FIRE:
            begin
                if (stat.out_free)
                begin
                    cmd.fire   = 1'b1;
                    state_next = stat.fire_last ? dtt_pkg::ST_IDLE : dtt_pkg::ST_SCAN;
                end
            end
            dtt_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.resp   = 1'b1;
                    state_next = dtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/dtt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_dp
// Datapath: slot table, scan accumulators, result register and config.
// ----------------------------------------------------------------------------
module dtt_dp
(
    input  logic               clk,
    input  logic               rst_n,
    dtt_in_if.sink             in_ch,
    dtt_out_if.source          out_ch,
    dtt_cfg_if.sink            cfg_ch,
    input  dtt_pkg::dtt_cmd_t  cmd,
    output dtt_pkg::dtt_stat_t stat
);

    localparam int IW = dtt_pkg::ID_W;
    localparam int TW = dtt_pkg::TIME_W;
    localparam int PW = dtt_pkg::PER_W;
    localparam int CW = dtt_pkg::CNT_W;
    localparam int N  = dtt_pkg::SLOTS;

    // slot table
    logic [TW-1:0] dl_reg  [N];
    logic [PW-1:0] per_reg [N];
    logic [N-1:0]  rep_reg;
    logic [N-1:0]  act_reg;
    logic [N-1:0]  done_reg;

    // operation registers
    logic [2:0]    func_reg;
    logic [PW-1:0] pin_reg;
    logic          rec_reg;
    logic          fnow_reg;
    logic [TW-1:0] now_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] slot_reg;
    logic [TW-1:0] new_dl_reg;
    logic [TW-1:0] start_reg;
    logic [TW-1:0] best_reg;
    logic          found_reg;
    logic [IW-1:0] pick_reg;
    logic          wake_ok_reg;
    logic          wake_en_reg;
    logic          res_ok_reg;
    logic          roll_reg;
    logic          first_reg;
    logic          surv_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] emit_reg;
    logic          latch_reg;
    logic [TW-1:0] prev_reg;
    logic [PW-1:0] win_reg;

    // result register
    logic          ov_reg;
    logic          o_ok_reg;
    logic [IW-1:0] o_slot_reg;
    logic          o_fired_reg;
    logic [TW-1:0] o_wait_reg;
    logic          o_wake_reg;
    logic          o_any_reg;
    logic          o_last_reg;

    logic [TW-1:0] e_dl;
    logic [PW-1:0] e_per;
    logic          e_act;
    logic          e_exp;
    logic          cand;
    logic          better;
    logic          found_n;
    logic [IW-1:0] pick_n;
    logic          full;
    logic [IW-1:0] free_idx;
    logic          same_per;
    logic          out_free;
    logic          wake_now;
    logic [TW-1:0] prev_minus;
    logic          roll_n;
    logic [TW-1:0] dl_less;

    // read the entry under the pointer
    assign e_dl  = dl_reg[idx_reg];
    assign e_per = per_reg[idx_reg];
    assign e_act = act_reg[idx_reg];
    assign e_exp = roll_reg || (e_dl <= now_reg);

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                free_idx = IW'(i);
                full     = 1'b0;
            end
        end
    end

    // scan candidate selection
    always_comb
    begin
        if (func_reg == dtt_pkg::FN_COLLECT)
        begin
            cand = e_act && !done_reg[idx_reg] && e_exp;
        end
        else
        begin
            cand = e_act;
        end
        better  = cmd.scan_step && cand && (!found_reg || (e_dl < best_reg));
        found_n = found_reg || better;
        pick_n  = better ? idx_reg : pick_reg;
    end

    assign same_per   = (pin_reg == e_per) && !fnow_reg;
    assign out_free   = !ov_reg || out_ch.ready;
    assign wake_now   = wake_en_reg && wake_ok_reg && !latch_reg;
    assign prev_minus = prev_reg - {{(TW-PW){1'b0}}, win_reg};
    assign roll_n     = (prev_reg >= {{(TW-PW){1'b0}}, win_reg}) && (now_reg < prev_minus);
    assign dl_less    = (e_dl >= {{(TW-PW){1'b0}}, e_per})
                        ? e_dl - {{(TW-PW){1'b0}}, e_per} : '0;

    assign stat.func        = func_reg;
    assign stat.full        = full;
    assign stat.reset_write = !same_per && e_act;
    assign stat.idx_last    = (idx_reg == IW'(N - 1));
    assign stat.found_n     = found_n;
    assign stat.fire_last   = ((emit_reg + CW'(1)) == cnt_reg);
    assign stat.out_free    = out_free;

    assign cfg_ch.ready = 1'b1;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= '0;
            done_reg  <= '0;
            latch_reg <= 1'b0;
            prev_reg  <= '0;
            win_reg   <= dtt_pkg::ROLL_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                win_reg <= cfg_ch.data;
            end
            // hold the result until taken, load a new one when issued
            if (cmd.fire || cmd.resp)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.exec)
            begin
                unique case (func_reg)
                    dtt_pkg::FN_ADD:
                        if (!full)
                        begin
                            act_reg[free_idx] <= 1'b1;
                        end
                    dtt_pkg::FN_CANCEL:
                        act_reg[idx_reg] <= 1'b0;
                    dtt_pkg::FN_QUERY:
                        latch_reg <= 1'b0;
                    dtt_pkg::FN_COLLECT:
                    begin
                        prev_reg <= now_reg;
                        done_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.fire)
            begin
                done_reg[idx_reg] <= 1'b1;
                if (!rep_reg[idx_reg])
                begin
                    act_reg[idx_reg] <= 1'b0;
                end
            end
            if (cmd.resp)
            begin
                if (wake_now)
                begin
                    latch_reg <= 1'b1;
                end
            end
        end
    end

    // table and payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_ch.func;
            pin_reg   <= in_ch.period_ms;
            rec_reg   <= in_ch.recurring;
            fnow_reg  <= in_ch.restart_now;
            now_reg   <= in_ch.now_ms;
            idx_reg   <= in_ch.timer_id;
        end
        if (cmd.exec)
        begin
            wake_en_reg <= 1'b0;
            wake_ok_reg <= 1'b1;
            res_ok_reg  <= 1'b0;
            slot_reg    <= '0;
            found_reg   <= 1'b0;
            first_reg   <= 1'b1;
            cnt_reg     <= '0;
            emit_reg    <= '0;
            surv_reg    <= 1'b0;
            unique case (func_reg)
                dtt_pkg::FN_ADD:
                begin
                    if (!full)
                    begin
                        dl_reg[free_idx]  <= dtt_pkg::sat_add(now_reg, pin_reg);
                        per_reg[free_idx] <= pin_reg;
                        rep_reg[free_idx] <= rec_reg;
                        new_dl_reg        <= dtt_pkg::sat_add(now_reg, pin_reg);
                        slot_reg          <= free_idx;
                        res_ok_reg        <= 1'b1;
                        wake_en_reg       <= 1'b1;
                        idx_reg           <= '0;
                    end
                end
                dtt_pkg::FN_CANCEL:
                    res_ok_reg <= e_act;
                dtt_pkg::FN_REFRESH:
                begin
                    res_ok_reg <= e_act;
                    if (e_act)
                    begin
                        dl_reg[idx_reg] <= dtt_pkg::sat_add(now_reg, e_per);
                    end
                end
                dtt_pkg::FN_RESET:
                begin
                    res_ok_reg <= same_per || e_act;
                    start_reg  <= fnow_reg ? now_reg : dl_less;
                end
                dtt_pkg::FN_QUERY:
                begin
                    res_ok_reg <= 1'b1;
                    idx_reg    <= '0;
                end
                dtt_pkg::FN_COLLECT:
                begin
                    res_ok_reg <= 1'b1;
                    roll_reg   <= roll_n;
                    idx_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.set_dl)
        begin
            dl_reg[idx_reg]  <= dtt_pkg::sat_add(start_reg, pin_reg);
            per_reg[idx_reg] <= pin_reg;
            new_dl_reg       <= dtt_pkg::sat_add(start_reg, pin_reg);
            slot_reg         <= idx_reg;
            wake_en_reg      <= 1'b1;
            idx_reg          <= '0;
        end
        if (cmd.scan_step)
        begin
            found_reg <= found_n;
            pick_reg  <= pick_n;
            if (better)
            begin
                best_reg <= e_dl;
            end
            // drop wake when another active deadline is not later
            if ((func_reg == dtt_pkg::FN_ADD || func_reg == dtt_pkg::FN_RESET) &&
                idx_reg != slot_reg && e_act && e_dl <= new_dl_reg)
            begin
                wake_ok_reg <= 1'b0;
            end
            if (func_reg == dtt_pkg::FN_COLLECT && first_reg)
            begin
                cnt_reg  <= cnt_reg + CW'(e_act && e_exp);
                surv_reg <= surv_reg || (e_act && (rep_reg[idx_reg] || !e_exp));
            end
            if (idx_reg == IW'(N - 1))
            begin
                first_reg <= 1'b0;
                idx_reg   <= (func_reg == dtt_pkg::FN_COLLECT) ? pick_n : '0;
            end
            else
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
        if (cmd.fire)
        begin
            if (rep_reg[idx_reg])
            begin
                dl_reg[idx_reg] <= dtt_pkg::sat_add(now_reg, e_per);
            end
            o_ok_reg    <= 1'b1;
            o_slot_reg  <= idx_reg;
            o_fired_reg <= 1'b1;
            o_wait_reg  <= '0;
            o_wake_reg  <= 1'b0;
            o_any_reg   <= surv_reg;
            o_last_reg  <= stat.fire_last;
            emit_reg    <= emit_reg + CW'(1);
            found_reg   <= 1'b0;
            idx_reg     <= '0;
        end
        if (cmd.resp)
        begin
            o_ok_reg    <= res_ok_reg;
            // of the non-fire results, only add reports a slot number
            o_slot_reg  <= (func_reg == dtt_pkg::FN_ADD) ? slot_reg : '0;
            o_fired_reg <= 1'b0;
            if (func_reg == dtt_pkg::FN_QUERY)
            begin
                o_wait_reg <= !found_reg ? {TW{1'b1}}
                            : (now_reg >= best_reg) ? '0 : best_reg - now_reg;
            end
            else
            begin
                o_wait_reg <= '0;
            end
            o_wake_reg  <= wake_now;
            o_any_reg   <= |act_reg;
            o_last_reg  <= 1'b1;
        end
    end

    assign out_ch.valid      = ov_reg;
    assign out_ch.ok         = o_ok_reg;
    assign out_ch.slot_id    = o_slot_reg;
    assign out_ch.fired      = o_fired_reg;
    assign out_ch.wait_ms    = o_wait_reg;
    assign out_ch.wake       = o_wake_reg;
    assign out_ch.any_active = o_any_reg;
    assign out_ch.last       = o_last_reg;

endmodule
